// ===== rtl/gri_pkg.sv =====
`default_nettype none

package gri_pkg;

    localparam int AXIS_W  = 16;
    localparam int SCALE_W = 10;
    localparam int PROD_W  = 27;
    localparam int HEAD_W  = 29;
    localparam int ANGLE_W = 12;
    localparam int QUOT_W  = 17;
    localparam int SAT_W   = QUOT_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_KIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOUNT_KIND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_FLAG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE    = 3'd6;

    localparam logic [3:0] MOUNT_K2 = 4'd2;
    localparam logic [3:0] MOUNT_K3 = 4'd3;
    localparam logic [3:0] MOUNT_K4 = 4'd4;
    localparam logic [3:0] MOUNT_K5 = 4'd5;
    localparam logic [3:0] MOUNT_K6 = 4'd6;
    localparam logic [3:0] MOUNT_K7 = 4'd7;
    localparam logic [3:0] MOUNT_K8 = 4'd8;
    localparam logic [3:0] MOUNT_K9 = 4'd9;

    localparam logic [SCALE_W-1:0] RATE_SCALE_RST = 10'd61;

    // x/800 = (x>>5)/25, x/40000 = (x>>6)/625; exact for 21-bit dividends
    localparam int  RCP25_SH   = 26;
    localparam int  RCP625_SH  = 31;
    localparam longint RCP25_L  = ((64'd1 << RCP25_SH) + 64'd24) / 64'd25;
    localparam longint RCP625_L = ((64'd1 << RCP625_SH) + 64'd624) / 64'd625;
    localparam logic [21:0] RCP25  = RCP25_L[21:0];
    localparam logic [21:0] RCP625 = RCP625_L[21:0];

    localparam logic signed [AXIS_W-1:0] RATE_LIMIT = 16'sd20000;
    localparam logic signed [SAT_W-1:0]  SAT_HI     = 18'sd32767;
    localparam logic signed [SAT_W-1:0]  SAT_LO     = -18'sd32768;
    localparam logic signed [HEAD_W-1:0] HALF_TURN  = 29'sd72000000;
    localparam logic signed [HEAD_W-1:0] FULL_TURN  = 29'sd144000000;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 12'sd1800;

    typedef struct packed {
        logic                      product_kind;
        logic [3:0]                mount_kind;
        logic                      adaptive_flag;
        logic signed [AXIS_W-1:0]  bias_x;
        logic signed [AXIS_W-1:0]  bias_y;
        logic signed [AXIS_W-1:0]  bias_z;
        logic [SCALE_W-1:0]        rate_scale;
    } gri_cfg_t;

    typedef struct packed {
        logic adv;
        logic take0;
        logic take1;
        logic take2;
        logic first;
    } gri_ctl_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0]  axis_x;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_z;
        logic signed [AXIS_W-1:0]  pitch_rate;
        logic signed [AXIS_W-1:0]  roll_rate;
        logic signed [AXIS_W-1:0]  yaw_rate;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } gri_res_t;

endpackage

`default_nettype wire

// ===== rtl/gri_in_if.sv =====
`default_nettype none

interface gri_in_if import gri_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] raw_x;
    logic signed [AXIS_W-1:0] raw_y;
    logic signed [AXIS_W-1:0] raw_z;
    logic                     yaw_enable;

    modport source (output valid, output raw_x, output raw_y, output raw_z,
                    output yaw_enable, input ready);
    modport sink (input valid, input raw_x, input raw_y, input raw_z,
                  input yaw_enable, output ready);
endinterface

`default_nettype wire

// ===== rtl/gri_out_if.sv =====
`default_nettype none

interface gri_out_if import gri_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic signed [AXIS_W-1:0]  pitch_rate;
    logic signed [AXIS_W-1:0]  roll_rate;
    logic signed [AXIS_W-1:0]  yaw_rate;
    logic signed [ANGLE_W-1:0] yaw_angle;

    modport source (output valid, output axis_x, output axis_y, output axis_z,
                    output pitch_rate, output roll_rate, output yaw_rate,
                    output yaw_angle, input ready);
    modport sink (input valid, input axis_x, input axis_y, input axis_z,
                  input pitch_rate, input roll_rate, input yaw_rate,
                  input yaw_angle, output ready);
endinterface

`default_nettype wire

// ===== rtl/gri_cfg_if.sv =====
`default_nettype none

interface gri_cfg_if import gri_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gri_remap.sv =====
`default_nettype none

module gri_remap import gri_pkg::*;
(
    input  gri_cfg_t                 cfg,
    input  logic signed [AXIS_W-1:0] raw_x,
    input  logic signed [AXIS_W-1:0] raw_y,
    input  logic signed [AXIS_W-1:0] raw_z,
    output logic signed [AXIS_W-1:0] ax,
    output logic signed [AXIS_W-1:0] ay,
    output logic signed [AXIS_W-1:0] az
);

    logic signed [AXIS_W-1:0] tx;
    logic signed [AXIS_W-1:0] ty;
    logic signed [AXIS_W-1:0] tz;

    always_comb
    begin
        if (cfg.product_kind)
        begin
            tx = raw_x;
            ty = -raw_y;
            tz = -raw_z;
            case (cfg.mount_kind)
                MOUNT_K2:
                begin
                    ax = -ty; ay = tx;  az = tz;
                end
                MOUNT_K3:
                begin
                    ax = -tx; ay = -ty; az = tz;
                end
                MOUNT_K4:
                begin
                    ax = ty;  ay = -tx; az = tz;
                end
                MOUNT_K5:
                begin
                    ax = tx;  ay = -ty; az = -tz;
                end
                MOUNT_K6:
                begin
                    ax = ty;  ay = tx;  az = -tz;
                end
                MOUNT_K7:
                begin
                    ax = -tx; ay = ty;  az = -tz;
                end
                MOUNT_K8:
                begin
                    ax = -ty; ay = -tx; az = -tz;
                end
                default:
                begin
                    ax = tx;  ay = ty;  az = tz;
                end
            endcase
        end
        else
        begin
            tx = -raw_x;
            ty = -raw_y;
            tz = raw_z;
            case (cfg.mount_kind)
                MOUNT_K9:
                begin
                    ax = -tx; ay = -ty; az = tz;
                end
                MOUNT_K8:
                begin
                    ax = -ty; ay = tx;  az = tz;
                end
                MOUNT_K6:
                begin
                    ax = ty;  ay = -tx; az = tz;
                end
                default:
                begin
                    ax = tx;  ay = ty;  az = tz;
                end
            endcase
        end
        if (!cfg.adaptive_flag)
        begin
            ax = -raw_x;
            ay = raw_y;
            az = -raw_z;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gri_lane.sv =====
`default_nettype none

module gri_lane import gri_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  gri_ctl_t                 ctl,
    input  logic signed [AXIS_W-1:0] axis,
    input  logic signed [AXIS_W-1:0] bias,
    input  logic [SCALE_W-1:0]       scale,
    output logic signed [PROD_W-1:0] prod,
    output logic signed [AXIS_W-1:0] rate
);

    logic signed [AXIS_W:0]      diff;
    logic signed [PROD_W:0]      prod_full;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]           mag;
    logic [42:0]                 recip;
    logic [QUOT_W-1:0]           quot_reg;
    logic                        neg_reg;
    logic signed [SAT_W-1:0]     quot_s;
    logic signed [AXIS_W-1:0]    sat;
    logic signed [AXIS_W-1:0]    last_reg;

    assign diff      = {axis[AXIS_W-1], axis} - {bias[AXIS_W-1], bias};
    assign prod_full = diff * $signed({1'b0, scale});

    always_ff @(posedge clk)
    begin
        if (ctl.take0)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
    end

    assign prod  = prod_reg;
    assign mag   = prod_reg[PROD_W-1] ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign recip = mag[PROD_W-2:5] * RCP25;

    always_ff @(posedge clk)
    begin
        if (ctl.take1)
        begin
            quot_reg <= recip[RCP25_SH+QUOT_W-1:RCP25_SH];
            neg_reg  <= prod_reg[PROD_W-1];
        end
    end

    always_comb
    begin
        quot_s = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
        if (quot_s > SAT_HI)
        begin
            sat = SAT_HI[AXIS_W-1:0];
        end
        else if (quot_s < SAT_LO)
        begin
            sat = SAT_LO[AXIS_W-1:0];
        end
        else
        begin
            sat = quot_s[AXIS_W-1:0];
        end
        if (!ctl.first && (sat > RATE_LIMIT || sat < -RATE_LIMIT))
        begin
            rate = last_reg;
        end
        else
        begin
            rate = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (ctl.take2)
        begin
            last_reg <= rate;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gri_heading.sv =====
`default_nettype none

module gri_heading import gri_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gri_ctl_t                  ctl,
    input  logic                      yaw_en,
    input  logic signed [PROD_W-1:0]  prod_z,
    output logic signed [HEAD_W-1:0]  heading,
    output logic signed [ANGLE_W-1:0] angle
);

    logic signed [HEAD_W-1:0]  heading_reg;
    logic signed [HEAD_W-1:0]  heading_next;
    logic signed [HEAD_W-1:0]  acc;
    logic signed [HEAD_W-1:0]  hd_reg;
    logic [HEAD_W-1:0]         mag;
    logic [42:0]               recip;
    logic [ANGLE_W-1:0]        quot;

    always_comb
    begin
        acc = heading_reg + {{(HEAD_W-PROD_W){prod_z[PROD_W-1]}}, prod_z};
        if (acc > HALF_TURN)
        begin
            acc = acc - FULL_TURN;
        end
        else if (acc < -HALF_TURN)
        begin
            acc = acc + FULL_TURN;
        end
        heading_next = yaw_en ? acc : heading_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg <= '0;
        end
        else if (ctl.take1)
        begin
            heading_reg <= heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take1)
        begin
            hd_reg <= heading_next;
        end
    end

    assign heading = heading_reg;
    assign mag     = hd_reg[HEAD_W-1] ? $unsigned(-hd_reg) : $unsigned(hd_reg);
    assign recip   = mag[HEAD_W-3:6] * RCP625;
    assign quot    = recip[RCP625_SH+ANGLE_W-1:RCP625_SH];
    assign angle   = hd_reg[HEAD_W-1] ? -$signed(quot) : $signed(quot);

endmodule

`default_nettype wire

// ===== rtl/gyro_remap_scale_integrate.sv =====
`default_nettype none

// Gyro remap, rate scaling, glitch filter and yaw integrator. One sample
// is taken every cycle unless the output stalls; its result moves through
// registered stages: remap and bias-times-scale multiply, reciprocal divide
// and heading update, then saturation, glitch filter and heading divide into
// the output register. When the result is not taken, the whole pipeline holds
// and sample.ready falls. Configuration writes are taken every cycle
// (cfg.ready is always high); write them only while no sample is in flight.
module gyro_remap_scale_integrate import gri_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gri_cfg_if.sink    cfg,
    gri_in_if.sink     sample,
    gri_out_if.source  result
);

    gri_cfg_t                  cfg_reg;
    gri_ctl_t                  ctl;
    gri_res_t                  out_reg;
    gri_res_t                  out_next;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      out_valid_reg;
    logic                      first_sample_reg;
    logic                      yaw_en_reg;
    logic signed [AXIS_W-1:0]  ax;
    logic signed [AXIS_W-1:0]  ay;
    logic signed [AXIS_W-1:0]  az;
    logic signed [AXIS_W-1:0]  ax1_reg;
    logic signed [AXIS_W-1:0]  ay1_reg;
    logic signed [AXIS_W-1:0]  az1_reg;
    logic signed [AXIS_W-1:0]  ax2_reg;
    logic signed [AXIS_W-1:0]  ay2_reg;
    logic signed [AXIS_W-1:0]  az2_reg;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
    logic signed [PROD_W-1:0]  prod_z;
    logic signed [AXIS_W-1:0]  rate_x;
    logic signed [AXIS_W-1:0]  rate_y;
    logic signed [AXIS_W-1:0]  rate_z;
    logic signed [HEAD_W-1:0]  heading;
    logic signed [ANGLE_W-1:0] angle;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.product_kind  <= 1'b1;
            cfg_reg.mount_kind    <= '0;
            cfg_reg.adaptive_flag <= 1'b1;
            cfg_reg.bias_x        <= '0;
            cfg_reg.bias_y        <= '0;
            cfg_reg.bias_z        <= '0;
            cfg_reg.rate_scale    <= RATE_SCALE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PRODUCT_KIND:  cfg_reg.product_kind  <= cfg.data[0];
                REG_MOUNT_KIND:    cfg_reg.mount_kind    <= cfg.data[3:0];
                REG_ADAPTIVE_FLAG: cfg_reg.adaptive_flag <= cfg.data[0];
                REG_BIAS_X:        cfg_reg.bias_x        <= $signed(cfg.data);
                REG_BIAS_Y:        cfg_reg.bias_y        <= $signed(cfg.data);
                REG_BIAS_Z:        cfg_reg.bias_z        <= $signed(cfg.data);
                REG_RATE_SCALE:    cfg_reg.rate_scale    <= cfg.data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // advance the pipe whenever the output register is free or drained
    assign ctl.adv   = !out_valid_reg || result.ready;
    assign ctl.take0 = sample.valid && ctl.adv;
    assign ctl.take1 = v1_reg && ctl.adv;
    assign ctl.take2 = v2_reg && ctl.adv;
    assign ctl.first = first_sample_reg;

    assign sample.ready = ctl.adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
            first_sample_reg <= 1'b1;
        end
        else
        begin
            if (ctl.adv)
            begin
                v1_reg        <= sample.valid;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg;
            end
            if (ctl.take2)
            begin
                first_sample_reg <= 1'b0;
            end
        end
    end

    gri_remap u_remap
    (
        .cfg   (cfg_reg),
        .raw_x (sample.raw_x),
        .raw_y (sample.raw_y),
        .raw_z (sample.raw_z),
        .ax    (ax),
        .ay    (ay),
        .az    (az)
    );

    gri_lane u_lane_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .axis  (ax),
        .bias  (cfg_reg.bias_x),
        .scale (cfg_reg.rate_scale),
        .prod  (prod_x),
        .rate  (rate_x)
    );

    gri_lane u_lane_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .axis  (ay),
        .bias  (cfg_reg.bias_y),
        .scale (cfg_reg.rate_scale),
        .prod  (prod_y),
        .rate  (rate_y)
    );

    gri_lane u_lane_z
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .axis  (az),
        .bias  (cfg_reg.bias_z),
        .scale (cfg_reg.rate_scale),
        .prod  (prod_z),
        .rate  (rate_z)
    );

    gri_heading u_heading
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .yaw_en  (yaw_en_reg),
        .prod_z  (prod_z),
        .heading (heading),
        .angle   (angle)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.take0)
        begin
            ax1_reg    <= ax;
            ay1_reg    <= ay;
            az1_reg    <= az;
            yaw_en_reg <= sample.yaw_enable;
        end
        if (ctl.take1)
        begin
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            az2_reg <= az1_reg;
        end
        if (ctl.take2)
        begin
            out_reg <= out_next;
        end
    end

    // merge lane results into one beat
    always_comb
    begin
        out_next.axis_x     = ax2_reg;
        out_next.axis_y     = ay2_reg;
        out_next.axis_z     = az2_reg;
        out_next.pitch_rate = rate_y;
        out_next.roll_rate  = rate_x;
        out_next.yaw_rate   = rate_z;
        out_next.yaw_angle  = angle;
    end

    assign result.valid      = out_valid_reg;
    assign result.axis_x     = out_reg.axis_x;
    assign result.axis_y     = out_reg.axis_y;
    assign result.axis_z     = out_reg.axis_z;
    assign result.pitch_rate = out_reg.pitch_rate;
    assign result.roll_rate  = out_reg.roll_rate;
    assign result.yaw_rate   = out_reg.yaw_rate;
    assign result.yaw_angle  = out_reg.yaw_angle;

`ifndef ASSERT_OFF
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading <= HALF_TURN && heading >= -HALF_TURN)
        else $error("heading accumulator out of range");

    a_first_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !first_sample_reg)
        else $error("first sample flag still set with a result pending");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.yaw_angle <= ANGLE_MAX
                           && out_reg.yaw_angle >= -ANGLE_MAX))
        else $error("yaw angle out of range");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && out_valid_reg && !result.ready) |=> v2_reg)
        else $error("stage two dropped a sample during a stall");
`endif

endmodule

`default_nettype wire
